// ===== hdl/ffha_pkg.sv =====
package ffha_pkg;

    // Heap geometry
    localparam int HEAP_BYTES   = 4096;
    localparam int ALIGN_BYTES  = 4;
    localparam int HEADER_BYTES = 8;

    // Headers always sit on an alignment granule, so the stores are indexed by granule
    localparam int GRAN_SHIFT = $clog2(ALIGN_BYTES);
    localparam int DEPTH      = HEAP_BYTES / ALIGN_BYTES;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int PTR_W      = IDX_W + 1;
    localparam int LEN_W      = $clog2(HEAP_BYTES) + 1;
    localparam int BA_W       = $clog2(HEAP_BYTES) + 2;
    localparam int SZ_W       = 14;

    // Port field widths
    localparam int REQ_SIZE_W = 13;
    localparam int OFF_W      = 12;
    localparam int ST_W       = 2;

    // Null link: one past the last granule
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(DEPTH);

    // Request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

    // Datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_IDLE   = 5'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 5'd2;
    localparam logic [OP_W-1:0] OP_A_RD   = 5'd3;
    localparam logic [OP_W-1:0] OP_A_EV   = 5'd4;
    localparam logic [OP_W-1:0] OP_A_PICK = 5'd5;
    localparam logic [OP_W-1:0] OP_A_W1   = 5'd6;
    localparam logic [OP_W-1:0] OP_A_W2   = 5'd7;
    localparam logic [OP_W-1:0] OP_F_RD   = 5'd8;
    localparam logic [OP_W-1:0] OP_F_CHK  = 5'd9;
    localparam logic [OP_W-1:0] OP_F_IRD  = 5'd10;
    localparam logic [OP_W-1:0] OP_F_IEV  = 5'd11;
    localparam logic [OP_W-1:0] OP_C1     = 5'd12;
    localparam logic [OP_W-1:0] OP_C2     = 5'd13;
    localparam logic [OP_W-1:0] OP_C3     = 5'd14;
    localparam logic [OP_W-1:0] OP_F_W1   = 5'd15;
    localparam logic [OP_W-1:0] OP_F_W2   = 5'd16;
    localparam logic [OP_W-1:0] OP_DONE   = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ST_W-1:0] res;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic head_null;
        logic off_ok;
        logic walk_done;
        logic found;
        logic mark_set;
        logic ins_head;
        logic ins_done;
    } stat_t;

endpackage

// ===== hdl/ffha_dp.sv =====
module ffha_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ffha_pkg::cmd_t                      cmd,
    input  logic                                req_type,
    input  logic [ffha_pkg::REQ_SIZE_W-1:0]     request_size,
    input  logic [ffha_pkg::OFF_W-1:0]          block_offset,
    output ffha_pkg::stat_t                     stat,
    output logic                                done,
    output logic [ffha_pkg::OFF_W-1:0]          data_offset,
    output logic [ffha_pkg::ST_W-1:0]           status
);

    localparam int IDX_W = ffha_pkg::IDX_W;
    localparam int PTR_W = ffha_pkg::PTR_W;
    localparam int LEN_W = ffha_pkg::LEN_W;
    localparam int BA_W  = ffha_pkg::BA_W;
    localparam int SZ_W  = ffha_pkg::SZ_W;
    localparam int OFF_W = ffha_pkg::OFF_W;
    localparam int ST_W  = ffha_pkg::ST_W;
    localparam int SH    = ffha_pkg::GRAN_SHIFT;

    // Block stores
    logic [LEN_W-1:0] len_mem  [ffha_pkg::DEPTH];
    logic [PTR_W-1:0] next_mem [ffha_pkg::DEPTH];
    logic             mark_mem [ffha_pkg::DEPTH];

    logic [LEN_W-1:0] len_rd_reg;
    logic [PTR_W-1:0] next_rd_reg;
    logic             mark_rd_reg;

    logic             len_we, next_we, mark_we;
    logic [IDX_W-1:0] len_wa, next_wa, mark_wa;
    logic [IDX_W-1:0] len_ra, next_ra, mark_ra;
    logic [LEN_W-1:0] len_wd;
    logic [PTR_W-1:0] next_wd;
    logic             mark_wd;

    // Control state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             done_reg, done_next;
    logic             eq_flag_reg, eq_flag_next;

    // Working registers
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0] trail_reg, trail_next;
    logic [IDX_W-1:0] h_reg, h_next;
    logic [PTR_W-1:0] p_reg, p_next;
    logic [PTR_W-1:0] nx_reg, nx_next;
    logic [PTR_W-1:0] nnx_reg, nnx_next;
    logic [PTR_W-1:0] link_reg, link_next;
    logic [LEN_W-1:0] lh_reg, lh_next;
    logic [LEN_W-1:0] lp_reg, lp_next;
    logic             tp_reg, tp_next;
    logic [SZ_W-1:0]  size_reg, size_next;
    logic [SZ_W-1:0]  need_reg, need_next;
    logic             off_ok_reg, off_ok_next;
    logic             rtype_reg, rtype_next;
    logic [OFF_W-1:0] doff_reg, doff_next;
    logic [ST_W-1:0]  st_reg, st_next;

    logic [SZ_W-1:0]  size_in;
    logic [OFF_W-1:0] free_fh;
    logic             len_gt, len_eq;
    logic [IDX_W-1:0] r_idx;
    logic [BA_W-1:0]  hb, pb, nxb;
    logic             tp, tn;
    logic [BA_W-1:0]  sum_p, sum_h;

    assign size_in = (SZ_W'(request_size) + SZ_W'(ffha_pkg::ALIGN_BYTES - 1))
                     & ~SZ_W'(ffha_pkg::ALIGN_BYTES - 1);
    assign free_fh = block_offset - OFF_W'(ffha_pkg::HEADER_BYTES);

    assign len_gt = {1'b0, len_rd_reg} > need_reg;
    assign len_eq = {1'b0, len_rd_reg} == need_reg;
    assign r_idx  = IDX_W'(BA_W'(h_reg) + BA_W'(need_reg >> SH));

    assign hb  = BA_W'(h_reg) << SH;
    assign pb  = BA_W'(p_reg[IDX_W-1:0]) << SH;
    assign nxb = BA_W'(nx_reg[IDX_W-1:0]) << SH;
    assign tp  = !p_reg[IDX_W]
                 && (pb + BA_W'(lp_reg) + BA_W'(ffha_pkg::HEADER_BYTES) == hb);
    assign tn  = !nx_reg[IDX_W]
                 && (hb + BA_W'(lh_reg) + BA_W'(ffha_pkg::HEADER_BYTES) == nxb);
    assign sum_h = BA_W'(lh_reg) + BA_W'(len_rd_reg) + BA_W'(ffha_pkg::HEADER_BYTES);
    assign sum_p = BA_W'(lp_reg) + BA_W'(lh_reg) + BA_W'(ffha_pkg::HEADER_BYTES)
                   + (tn ? BA_W'(len_rd_reg) + BA_W'(ffha_pkg::HEADER_BYTES) : '0);

    always_comb
    begin
        head_next    = head_reg;
        clr_next     = clr_reg;
        done_next    = 1'b0;
        eq_flag_next = eq_flag_reg;
        cur_next     = cur_reg;
        trail_next   = trail_reg;
        h_next       = h_reg;
        p_next       = p_reg;
        nx_next      = nx_reg;
        nnx_next     = nnx_reg;
        link_next    = link_reg;
        lh_next      = lh_reg;
        lp_next      = lp_reg;
        tp_next      = tp_reg;
        size_next    = size_reg;
        need_next    = need_reg;
        off_ok_next  = off_ok_reg;
        rtype_next   = rtype_reg;
        doff_next    = doff_reg;
        st_next      = st_reg;

        len_we  = 1'b0;
        len_wa  = h_reg;
        len_wd  = '0;
        next_we = 1'b0;
        next_wa = h_reg;
        next_wd = nx_reg;
        mark_we = 1'b0;
        mark_wa = h_reg;
        mark_wd = 1'b0;
        len_ra  = cur_reg[IDX_W-1:0];
        next_ra = cur_reg[IDX_W-1:0];
        mark_ra = h_reg;

        case (cmd.op)
            ffha_pkg::OP_CLEAR:
            begin
                len_we   = 1'b1;
                len_wa   = clr_reg;
                len_wd   = (clr_reg == '0)
                           ? LEN_W'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES) : '0;
                next_we  = 1'b1;
                next_wa  = clr_reg;
                next_wd  = (clr_reg == '0) ? ffha_pkg::NIL_PTR : '0;
                mark_we  = 1'b1;
                mark_wa  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ffha_pkg::OP_LOAD:
            begin
                rtype_next   = req_type;
                size_next    = size_in;
                need_next    = size_in + SZ_W'(ffha_pkg::HEADER_BYTES);
                h_next       = IDX_W'(free_fh >> SH);
                off_ok_next  = (block_offset >= OFF_W'(ffha_pkg::HEADER_BYTES))
                               && ((free_fh & OFF_W'(ffha_pkg::ALIGN_BYTES - 1)) == '0);
                cur_next     = head_reg;
                trail_next   = ffha_pkg::NIL_PTR;
                eq_flag_next = 1'b0;
            end
            ffha_pkg::OP_A_EV:
            begin
                // First longer block wins; else remember the first exact fit
                if (len_gt)
                begin
                    h_next = cur_reg[IDX_W-1:0];
                    p_next = trail_reg;
                end
                else if (len_eq && !eq_flag_reg)
                begin
                    h_next       = cur_reg[IDX_W-1:0];
                    p_next       = trail_reg;
                    eq_flag_next = 1'b1;
                end
                trail_next = cur_reg;
                cur_next   = next_rd_reg;
            end
            ffha_pkg::OP_A_PICK:
            begin
                len_ra  = h_reg;
                next_ra = h_reg;
            end
            ffha_pkg::OP_A_W1:
            begin
                // Remnant takes the block's place in the list
                len_we  = 1'b1;
                len_wa  = r_idx;
                len_wd  = LEN_W'(SZ_W'(len_rd_reg) - need_reg);
                next_we = 1'b1;
                next_wa = r_idx;
                next_wd = next_rd_reg;
                mark_we = 1'b1;
                mark_wd = 1'b1;
            end
            ffha_pkg::OP_A_W2:
            begin
                len_we = 1'b1;
                len_wd = LEN_W'(size_reg);
                if (p_reg[IDX_W])
                begin
                    head_next = {1'b0, r_idx};
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = p_reg[IDX_W-1:0];
                    next_wd = {1'b0, r_idx};
                end
            end
            ffha_pkg::OP_F_CHK:
            begin
                if (mark_rd_reg)
                begin
                    mark_we  = 1'b1;
                    cur_next = head_reg;
                    if (stat.ins_head)
                    begin
                        p_next  = ffha_pkg::NIL_PTR;
                        nx_next = head_reg;
                    end
                end
            end
            ffha_pkg::OP_F_IEV:
            begin
                if (stat.ins_done)
                begin
                    p_next  = cur_reg;
                    nx_next = next_rd_reg;
                end
                else
                begin
                    cur_next = next_rd_reg;
                end
            end
            ffha_pkg::OP_C1:
            begin
                len_ra  = h_reg;
                next_ra = nx_reg[IDX_W-1:0];
            end
            ffha_pkg::OP_C2:
            begin
                lh_next  = len_rd_reg;
                nnx_next = next_rd_reg;
                len_ra   = p_reg[IDX_W-1:0];
            end
            ffha_pkg::OP_C3:
            begin
                lp_next = len_rd_reg;
                len_ra  = nx_reg[IDX_W-1:0];
            end
            ffha_pkg::OP_F_W1:
            begin
                next_we = 1'b1;
                next_wd = (tn && !tp) ? nnx_reg : nx_reg;
                if (tp)
                begin
                    len_we = 1'b1;
                    len_wa = p_reg[IDX_W-1:0];
                    len_wd = LEN_W'(sum_p);
                end
                else if (tn)
                begin
                    len_we = 1'b1;
                    len_wd = LEN_W'(sum_h);
                end
                tp_next   = tp;
                link_next = tn ? nnx_reg : nx_reg;
            end
            ffha_pkg::OP_F_W2:
            begin
                if (p_reg[IDX_W])
                begin
                    head_next = {1'b0, h_reg};
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = p_reg[IDX_W-1:0];
                    next_wd = tp_reg ? link_reg : {1'b0, h_reg};
                end
            end
            ffha_pkg::OP_DONE:
            begin
                done_next = 1'b1;
                st_next   = cmd.res;
                doff_next = (cmd.res == ffha_pkg::ST_OK && rtype_reg == ffha_pkg::REQ_ALLOC)
                            ? OFF_W'(hb + BA_W'(ffha_pkg::HEADER_BYTES)) : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.clr_last  = (clr_reg == IDX_W'(ffha_pkg::DEPTH - 1));
        stat.head_null = head_reg[IDX_W];
        stat.off_ok    = off_ok_reg;
        stat.walk_done = len_gt || next_rd_reg[IDX_W];
        stat.found     = len_gt || len_eq || eq_flag_reg;
        stat.mark_set  = mark_rd_reg;
        stat.ins_head  = head_reg > {1'b0, h_reg};
        stat.ins_done  = next_rd_reg > {1'b0, h_reg};
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        len_rd_reg <= len_mem[len_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd_reg <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd_reg <= mark_mem[mark_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
            eq_flag_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            clr_reg     <= clr_next;
            done_reg    <= done_next;
            eq_flag_reg <= eq_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        trail_reg  <= trail_next;
        h_reg      <= h_next;
        p_reg      <= p_next;
        nx_reg     <= nx_next;
        nnx_reg    <= nnx_next;
        link_reg   <= link_next;
        lh_reg     <= lh_next;
        lp_reg     <= lp_next;
        tp_reg     <= tp_next;
        size_reg   <= size_next;
        need_reg   <= need_next;
        off_ok_reg <= off_ok_next;
        rtype_reg  <= rtype_next;
        doff_reg   <= doff_next;
        st_reg     <= st_next;
    end

    assign done        = done_reg;
    assign data_offset = doff_reg;
    assign status      = st_reg;

    a_split_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ffha_pkg::OP_A_W1) |-> ({1'b0, len_rd_reg} >= need_reg))
        else $error("split of a block shorter than the request");

    a_prev_below: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ffha_pkg::OP_F_W2 && !p_reg[IDX_W]) |-> (p_reg < {1'b0, h_reg}))
        else $error("insert predecessor not below freed header");

    a_free_checked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ffha_pkg::OP_F_CHK && mark_rd_reg) |-> off_ok_reg)
        else $error("free proceeded on a malformed offset");

endmodule

// ===== hdl/ffha_ctrl.sv =====
module ffha_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            req_type,
    input  ffha_pkg::stat_t stat,
    output ffha_pkg::cmd_t  cmd,
    output logic            busy
);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_A_RD   = 5'd2;
    localparam logic [4:0] S_A_EV   = 5'd3;
    localparam logic [4:0] S_A_PICK = 5'd4;
    localparam logic [4:0] S_A_W1   = 5'd5;
    localparam logic [4:0] S_A_W2   = 5'd6;
    localparam logic [4:0] S_F_RD   = 5'd7;
    localparam logic [4:0] S_F_CHK  = 5'd8;
    localparam logic [4:0] S_F_IRD  = 5'd9;
    localparam logic [4:0] S_F_IEV  = 5'd10;
    localparam logic [4:0] S_C1     = 5'd11;
    localparam logic [4:0] S_C2     = 5'd12;
    localparam logic [4:0] S_C3     = 5'd13;
    localparam logic [4:0] S_F_W1   = 5'd14;
    localparam logic [4:0] S_F_W2   = 5'd15;
    localparam logic [4:0] S_DONE   = 5'd16;

    logic [4:0]                state_reg, state_next;
    logic [ffha_pkg::ST_W-1:0] res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.op     = ffha_pkg::OP_IDLE;
        cmd.res    = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = ffha_pkg::OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = ffha_pkg::OP_LOAD;
                    if (req_type == ffha_pkg::REQ_FREE)
                    begin
                        state_next = S_F_RD;
                    end
                    else if (stat.head_null)
                    begin
                        res_next   = ffha_pkg::ST_NOMEM;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_A_RD;
                    end
                end
            end
            S_A_RD:
            begin
                cmd.op     = ffha_pkg::OP_A_RD;
                state_next = S_A_EV;
            end
            S_A_EV:
            begin
                cmd.op = ffha_pkg::OP_A_EV;
                if (stat.walk_done)
                begin
                    if (stat.found)
                    begin
                        state_next = S_A_PICK;
                    end
                    else
                    begin
                        res_next   = ffha_pkg::ST_NOMEM;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_PICK:
            begin
                cmd.op     = ffha_pkg::OP_A_PICK;
                state_next = S_A_W1;
            end
            S_A_W1:
            begin
                cmd.op     = ffha_pkg::OP_A_W1;
                state_next = S_A_W2;
            end
            S_A_W2:
            begin
                cmd.op     = ffha_pkg::OP_A_W2;
                res_next   = ffha_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_F_RD:
            begin
                cmd.op = ffha_pkg::OP_F_RD;
                if (stat.off_ok)
                begin
                    state_next = S_F_CHK;
                end
                else
                begin
                    res_next   = ffha_pkg::ST_BADFREE;
                    state_next = S_DONE;
                end
            end
            S_F_CHK:
            begin
                cmd.op = ffha_pkg::OP_F_CHK;
                if (!stat.mark_set)
                begin
                    res_next   = ffha_pkg::ST_BADFREE;
                    state_next = S_DONE;
                end
                else if (stat.ins_head)
                begin
                    state_next = S_C1;
                end
                else
                begin
                    state_next = S_F_IRD;
                end
            end
            S_F_IRD:
            begin
                cmd.op     = ffha_pkg::OP_F_IRD;
                state_next = S_F_IEV;
            end
            S_F_IEV:
            begin
                cmd.op     = ffha_pkg::OP_F_IEV;
                state_next = stat.ins_done ? S_C1 : S_F_IRD;
            end
            S_C1:
            begin
                cmd.op     = ffha_pkg::OP_C1;
                state_next = S_C2;
            end
            S_C2:
            begin
                cmd.op     = ffha_pkg::OP_C2;
                state_next = S_C3;
            end
            S_C3:
            begin
                cmd.op     = ffha_pkg::OP_C3;
                state_next = S_F_W1;
            end
            S_F_W1:
            begin
                cmd.op     = ffha_pkg::OP_F_W1;
                state_next = S_F_W2;
            end
            S_F_W2:
            begin
                cmd.op     = ffha_pkg::OP_F_W2;
                res_next   = ffha_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.op     = ffha_pkg::OP_DONE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            res_reg   <= ffha_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(state_reg) == S_DONE || $past(state_reg) == S_CLEAR))
        else $error("busy dropped before a result or the clearing pass ended");

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a 4096-byte heap of headed blocks kept in an
// address-ordered free list. Pulse start while busy is low to transfer one
// request; exactly one result follows as a one-cycle done strobe with
// data_offset and status, and the receiver cannot stall it, so capture it on
// that cycle. After reset the block runs a clearing pass over every entry of
// its block stores with busy high. Allocation walks the free list with one
// registered memory read and one compare per visited block, then picks the
// block, writes the remnant and links it in. A free walks past the free
// blocks that lie below the freed one, reads its neighbours and coalesces;
// a rejected free returns without a walk. The walk through the list memory
// sets how long a request takes.
module first_fit_heap_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                req_type,
    input  logic [ffha_pkg::REQ_SIZE_W-1:0]     request_size,
    input  logic [ffha_pkg::OFF_W-1:0]          block_offset,
    output logic                                busy,
    output logic                                done,
    output logic [ffha_pkg::OFF_W-1:0]          data_offset,
    output logic [ffha_pkg::ST_W-1:0]           status
);

    // Commands down to the datapath, status back up to the sequencer
    ffha_pkg::cmd_t  cmd;
    ffha_pkg::stat_t stat;

    // Sequencer: clearing pass, list walks, write-back order, result code
    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Datapath: block stores, walk pointers, split and coalesce arithmetic
    ffha_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req_type),
        .request_size (request_size),
        .block_offset (block_offset),
        .stat         (stat),
        .done         (done),
        .data_offset  (data_offset),
        .status       (status)
    );

endmodule

// ===== test/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int unsigned NIL_ADDR   = HEAP_BYTES;
    localparam int unsigned WALK_MAX   = HEAP_BYTES / HEADER_BYTES + 2;
    localparam int          CYCLE_CAP  = 4000000;
    localparam int          RANDOM_OPS = 1400;

    typedef struct {
        logic [OFF_W-1:0] offset;
        logic [ST_W-1:0]  st;
    } heap_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  req_type;
    logic [REQ_SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]      block_offset;
    logic                  busy;
    logic                  done;
    logic [OFF_W-1:0]      data_offset;
    logic [ST_W-1:0]       status;

    // Shadow heap, indexed by the byte address of a block header
    int unsigned  heap_len  [HEAP_BYTES];
    int unsigned  heap_link [HEAP_BYTES];
    bit           heap_used [HEAP_BYTES];
    int unsigned  heap_first;

    heap_result_t results_pending[$];
    int unsigned  live_offsets[$];
    int           error_count;
    int           result_count;
    int           cycle_count;
    int           nomem_count;
    int           badfree_count;
    int           alloc_count;
    int           free_count;

    first_fit_heap_allocator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .request_size (request_size),
        .block_offset (block_offset),
        .busy         (busy),
        .done         (done),
        .data_offset  (data_offset),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: end the run if the block stops answering
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow heap helpers; addresses at or past the heap end read as null
    // ------------------------------------------------------------------
    function automatic int unsigned len_of(int unsigned a);
        return (a < HEAP_BYTES) ? heap_len[a] : 0;
    endfunction

    function automatic int unsigned link_of(int unsigned a);
        return (a < HEAP_BYTES) ? heap_link[a] : NIL_ADDR;
    endfunction

    function automatic void set_len(int unsigned a, int unsigned v);
        if (a < HEAP_BYTES)
            heap_len[a] = v;
    endfunction

    function automatic void set_link(int unsigned a, int unsigned v);
        if (a < HEAP_BYTES)
            heap_link[a] = v;
    endfunction

    function automatic void clear_heap();
        for (int i = 0; i < HEAP_BYTES; i++)
        begin
            heap_len[i]  = 0;
            heap_link[i] = 0;
            heap_used[i] = 1'b0;
        end
        heap_len[0]  = HEAP_BYTES - HEADER_BYTES;
        heap_link[0] = NIL_ADDR;
        heap_first   = 0;
    endfunction

    // Walk the free list for the first block longer than need, or at least need
    function automatic int unsigned first_fit(int unsigned need, bit exact_pass);
        int unsigned n;
        int unsigned l;
        n = heap_first;
        for (int k = 0; n != NIL_ADDR && k < WALK_MAX; k++)
        begin
            l = len_of(n);
            if (exact_pass ? (l >= need) : (l > need))
                return n;
            n = link_of(n);
        end
        return NIL_ADDR;
    endfunction

    function automatic void drop_from_list(int unsigned h);
        int unsigned n;
        n = heap_first;
        if (n == h)
        begin
            heap_first = link_of(h);
            return;
        end
        for (int k = 0; n != NIL_ADDR && k < WALK_MAX; k++)
        begin
            if (link_of(n) == h)
            begin
                set_link(n, link_of(h));
                return;
            end
            n = link_of(n);
        end
    endfunction

    function automatic heap_result_t predict_alloc(int unsigned req);
        heap_result_t res;
        int unsigned  size;
        int unsigned  need;
        int unsigned  h;
        int unsigned  r;
        size = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        need = size + HEADER_BYTES;
        h = first_fit(need, 1'b0);
        if (h == NIL_ADDR)
            h = first_fit(need, 1'b1);
        if (h >= HEAP_BYTES)
        begin
            res.offset = '0;
            res.st     = ST_NOMEM;
            return res;
        end
        // Split: the remnant (possibly zero length) inherits the old link
        r = h + need;
        set_len(r, len_of(h) - need);
        set_link(r, link_of(h));
        set_len(h, size);
        set_link(h, r);
        drop_from_list(h);
        set_link(h, NIL_ADDR);
        heap_used[h] = 1'b1;
        res.offset = OFF_W'(h + HEADER_BYTES);
        res.st     = ST_OK;
        return res;
    endfunction

    function automatic bit adjoins(int unsigned a, int unsigned b);
        return a != NIL_ADDR && b != NIL_ADDR && a + len_of(a) + HEADER_BYTES == b;
    endfunction

    function automatic heap_result_t predict_free(int unsigned off);
        heap_result_t res;
        int unsigned  h;
        int unsigned  prev;
        int unsigned  nx;
        int unsigned  n;
        int unsigned  m;
        res.offset = '0;
        if (off < HEADER_BYTES || off - HEADER_BYTES >= HEAP_BYTES ||
            !heap_used[off - HEADER_BYTES])
        begin
            res.st = ST_BADFREE;
            return res;
        end
        h = off - HEADER_BYTES;
        heap_used[h] = 1'b0;
        prev = NIL_ADDR;
        // Insert in address order
        if (heap_first == NIL_ADDR || heap_first > h)
        begin
            set_link(h, heap_first);
            heap_first = h;
        end
        else
        begin
            n = heap_first;
            for (int k = 0; k < WALK_MAX; k++)
            begin
                m = link_of(n);
                if (m == NIL_ADDR || m > h)
                    break;
                n = m;
            end
            set_link(h, link_of(n));
            set_link(n, h);
            prev = n;
        end
        // Merge with the immediate neighbours only
        nx = link_of(h);
        if (adjoins(prev, h))
        begin
            if (adjoins(h, nx))
            begin
                set_len(prev, len_of(prev) + len_of(h) + len_of(nx) + 2 * HEADER_BYTES);
                set_link(prev, link_of(nx));
            end
            else
            begin
                set_len(prev, len_of(prev) + len_of(h) + HEADER_BYTES);
                set_link(prev, nx);
            end
        end
        else if (adjoins(h, nx))
        begin
            set_len(h, len_of(h) + len_of(nx) + HEADER_BYTES);
            set_link(h, link_of(nx));
        end
        res.st = ST_OK;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: one result per done strobe, in request order
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (results_pending.size() == 0)
                report_mismatch("unexpected result, data_offset", data_offset, -1);
            else
            begin
                want = results_pending.pop_front();
                if (data_offset !== want.offset)
                    report_mismatch("data_offset", data_offset, want.offset);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Hold start and the fields until a transfer happens, then predict it.
    // Leave start high; the next call or an idle stretch decides its fate.
    task automatic send_request(input logic kind, input int unsigned size,
                                input int unsigned off);
        heap_result_t res;
        req_type     = kind;
        request_size = REQ_SIZE_W'(size);
        block_offset = OFF_W'(off);
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (kind == REQ_ALLOC)
        begin
            res = predict_alloc(size & 13'h1FFF);
            alloc_count++;
            if (res.st == ST_OK)
                live_offsets.push_back(res.offset);
            else
                nomem_count++;
        end
        else
        begin
            res = predict_free(off & 12'hFFF);
            free_count++;
            if (res.st == ST_BADFREE)
                badfree_count++;
        end
        results_pending.push_back(res);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic alloc_bytes(input int unsigned size);
        send_request(REQ_ALLOC, size, $urandom_range(4095));
    endtask

    task automatic free_offset(input int unsigned off);
        int idx[$];
        idx = live_offsets.find_first_index(x) with (x == off);
        if (idx.size() > 0)
            live_offsets.delete(idx[0]);
        send_request(REQ_FREE, $urandom_range(8191), off);
    endtask

    // Pause the sender until every outstanding result has come back
    task automatic drain_results();
        start = 1'b0;
        while (results_pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed_alloc();
        int unsigned a;
        int unsigned b;
        int unsigned c;
        alloc_bytes(0);                       // zero size
        alloc_bytes(1);                       // rounds up
        alloc_bytes(5);
        a = live_offsets[0];
        b = live_offsets[1];
        c = live_offsets[2];
        alloc_bytes(4096);                    // too large
        alloc_bytes(8191);                    // all size bits set
        free_offset(a);                       // head insert
        free_offset(c);                       // merges with tail
        free_offset(b);                       // merges both sides
        drain_results();
        alloc_bytes(HEAP_BYTES - 2 * HEADER_BYTES);  // exact fit of whole heap
        alloc_bytes(0);                       // nothing left
        free_offset(live_offsets[0]);
        drain_results();
    endtask

    task automatic test_directed_bad_free();
        int unsigned a;
        send_request(REQ_FREE, 0, 0);         // below header
        send_request(REQ_FREE, 0, 4);
        send_request(REQ_FREE, 0, 4095);      // all offset bits set
        send_request(REQ_FREE, 0, 8);         // never allocated
        alloc_bytes(12);
        a = live_offsets[0];
        send_request(REQ_FREE, 0, a + 2);     // unaligned
        free_offset(a);
        send_request(REQ_FREE, 0, a);         // double free
        drain_results();
    endtask

    task automatic test_random_traffic();
        int p;
        int unsigned sz;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            p = $urandom_range(99);
            if (p < 50 || live_offsets.size() == 0)
            begin
                p = $urandom_range(99);
                if (p < 80)
                    sz = $urandom_range(0, 96);
                else if (p < 95)
                    sz = $urandom_range(97, 1024);
                else
                    sz = $urandom_range(0, 8191);
                alloc_bytes(sz);
            end
            else if (p < 92)
                free_offset(live_offsets[$urandom_range(live_offsets.size() - 1)]);
            else
                send_request(REQ_FREE, $urandom_range(8191), $urandom_range(4095));
            idle_cycles(pick_gap());
            if (i % 300 == 299)
                drain_results();
        end
    endtask

    task automatic test_release_all();
        while (live_offsets.size() != 0)
        begin
            free_offset(live_offsets[$urandom_range(live_offsets.size() - 1)]);
            idle_cycles(pick_gap());
        end
        alloc_bytes(HEAP_BYTES - 2 * HEADER_BYTES);  // heap must be whole again
        free_offset(live_offsets[0]);
    endtask

    initial
    begin
        error_count   = 0;
        result_count  = 0;
        cycle_count   = 0;
        nomem_count   = 0;
        badfree_count = 0;
        alloc_count   = 0;
        free_count    = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        req_type      = REQ_ALLOC;
        request_size  = '0;
        block_offset  = '0;
        clear_heap();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed_alloc();
        test_directed_bad_free();
        test_random_traffic();
        test_release_all();

        drain_results();
        repeat (50) @(negedge clk);

        $display("Covered %0d allocate and %0d free transfers, %0d results checked",
                 alloc_count, free_count, result_count);
        $display("including %0d out-of-memory and %0d rejected frees",
                 nomem_count, badfree_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
